// ===== src/rbde_pkg.sv =====
// Shared types, constants and conversion helpers for the RTC BCD date/time encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rbde_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic [6:0]  SEC_LIMIT    = 7'd60;
   localparam logic [6:0]  HOUR_LIMIT   = 7'd24;
   localparam logic [3:0]  MONTH_FEB    = 4'd2;
   localparam logic [3:0]  MONTH_JAN    = 4'd1;
   localparam logic [3:0]  MONTH_LAST   = 4'd12;
   localparam logic [4:0]  LEN_DEFAULT  = 5'd31;
   localparam logic [11:0] YEAR_SAT     = 12'd2100;
   localparam logic [11:0] YEAR_BASE_20 = 12'd2000;
   localparam logic [11:0] YEAR_BASE_19 = 12'd1900;
   localparam logic [6:0]  YEAR_MAX_BIN = 7'd99;

   typedef struct packed {
      logic [6:0]  second;
      logic [6:0]  minute;
      logic [6:0]  hour;
      logic [5:0]  day_of_month;
      logic [3:0]  month_number;
      logic [11:0] year_full;
   } dt_in_type;

   typedef struct packed {
      logic [6:0] second_bcd;
      logic [6:0] minute_bcd;
      logic [5:0] hour_bcd;
      logic [5:0] day_bcd;
      logic [2:0] weekday_code;
      logic [7:0] month_century_reg;
      logic [7:0] year_bcd;
      logic       month_invalid;
   } dt_out_type;

   // Binary 0..99 to two BCD digits; tens via reciprocal 205/2048.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [17:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = {11'd0, v} * 18'd205;
      tens = prod[14:11];
      ones = v - ({3'd0, tens} * 7'd10);
      return {tens, ones[3:0]};
   endfunction

   // floor(y / 100) for 12-bit y, reciprocal 5243 / 2^19.
   function automatic logic [5:0] div100(input logic [11:0] y);
      logic [24:0] prod;
      prod = {13'd0, y} * 25'd5243;
      return prod[24:19];
   endfunction

   // floor(3 * (m + 1) / 5) for m up to 15.
   function automatic logic [3:0] month_term(input logic [3:0] m);
      logic [5:0] x;
      logic [9:0] prod;
      x    = ({2'd0, m} + 6'd1) * 6'd3;
      prod = {4'd0, x} * 10'd13;
      return prod[9:6];
   endfunction

   // Residue mod 7 by folding octal digits (8 = 1 mod 7).
   function automatic logic [2:0] mod7(input logic [12:0] v);
      logic [5:0] s1;
      logic [3:0] s2;
      s1 = {3'd0, v[2:0]} + {3'd0, v[5:3]} + {3'd0, v[8:6]} + {3'd0, v[11:9]}
           + {5'd0, v[12]};
      s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
      if (s2 >= 4'd7) begin
         s2 = s2 - 4'd7;
      end
      return s2[2:0];
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = 5'd28;
         default:                                     len = LEN_DEFAULT;
      endcase
      return len;
   endfunction

endpackage

// ===== src/rbde_weekday.sv =====
// Weekday from a Zeller-style sum on the unclamped day, month and year.
// Depends on rbde_pkg.
`timescale 1ns / 1ps

module rbde_weekday (
   input  logic [5:0]  day_of_month,
   input  logic [3:0]  month_number,
   input  logic [11:0] year_full,
   output logic [2:0]  weekday_code
);

   logic        early;
   logic [3:0]  m_adj;
   logic [11:0] y_adj;
   logic [5:0]  q100;
   logic [12:0] total;

   // January and February count as months 13 and 14 of the year before
   assign early = (month_number == rbde_pkg::MONTH_JAN) || (month_number == rbde_pkg::MONTH_FEB);
   assign m_adj = early ? (month_number + 4'd12) : month_number;
   assign y_adj = (early && (year_full != 12'd0)) ? (year_full - 12'd1)
                : (early ? 12'd0 : year_full);
   assign q100  = rbde_pkg::div100(y_adj);

   assign total = {7'd0, day_of_month} + {8'd0, m_adj, 1'b0}
                + {9'd0, rbde_pkg::month_term(m_adj)} + {1'b0, y_adj}
                + {3'd0, y_adj[11:2]} - {7'd0, q100} + {9'd0, q100[5:2]} + 13'd1;

   assign weekday_code = rbde_pkg::mod7(total);

endmodule

// ===== src/rbde_encode.sv =====
// Combinational conversion of one binary date/time beat to the RTC register bytes.
// Depends on rbde_pkg and rbde_weekday.
`timescale 1ns / 1ps

module rbde_encode (
   input  rbde_pkg::dt_in_type  dt_in,
   output rbde_pkg::dt_out_type dt_out
);

   logic        bad_month;
   logic [5:0]  q100;
   logic [11:0] rem100;
   logic        leap;
   logic [4:0]  mlen;
   logic [4:0]  dval;
   logic [6:0]  yval;
   logic        century;
   logic [6:0]  sec_v;
   logic [6:0]  min_v;
   logic [6:0]  hour_v;
   logic [7:0]  sec_b;
   logic [7:0]  min_b;
   logic [7:0]  hour_b;
   logic [7:0]  day_b;
   logic [7:0]  mon_b;
   logic [7:0]  year_b;
   logic [2:0]  weekday;

   assign bad_month = (dt_in.month_number == 4'd0) || (dt_in.month_number > rbde_pkg::MONTH_LAST);

   // leap: divisible by 4 but not 100, or by 400 (rem 0 and quotient divisible by 4)
   assign q100   = rbde_pkg::div100(dt_in.year_full);
   assign rem100 = dt_in.year_full - ({6'd0, q100} * 12'd100);
   assign leap   = ((dt_in.year_full[1:0] == 2'd0) && (rem100 != 12'd0))
                || ((rem100 == 12'd0) && (q100[1:0] == 2'd0));

   always_comb begin
      mlen = rbde_pkg::month_days(dt_in.month_number);
      if (!bad_month && (dt_in.month_number == rbde_pkg::MONTH_FEB) && leap) begin
         mlen = mlen + 5'd1;
      end
   end

   always_comb begin
      priority if ({1'b0, dt_in.day_of_month} > {2'b0, mlen}) begin
         dval = mlen;
      end else if (dt_in.day_of_month != 6'd0) begin
         dval = dt_in.day_of_month[4:0];
      end else begin
         dval = 5'd1;
      end
   end

   always_comb begin
      priority if (dt_in.year_full >= rbde_pkg::YEAR_SAT) begin
         yval    = rbde_pkg::YEAR_MAX_BIN;
         century = 1'b0;
      end else if (dt_in.year_full >= rbde_pkg::YEAR_BASE_20) begin
         yval    = 7'(dt_in.year_full - rbde_pkg::YEAR_BASE_20);
         century = 1'b0;
      end else if (dt_in.year_full >= rbde_pkg::YEAR_BASE_19) begin
         yval    = 7'(dt_in.year_full - rbde_pkg::YEAR_BASE_19);
         century = 1'b1;
      end else begin
         yval    = 7'd0;
         century = 1'b1;
      end
   end

   assign sec_v  = (dt_in.second < rbde_pkg::SEC_LIMIT) ? dt_in.second : 7'd0;
   assign min_v  = (dt_in.minute < rbde_pkg::SEC_LIMIT) ? dt_in.minute : 7'd0;
   assign hour_v = (dt_in.hour < rbde_pkg::HOUR_LIMIT) ? dt_in.hour : 7'd0;

   assign sec_b  = rbde_pkg::to_bcd(sec_v);
   assign min_b  = rbde_pkg::to_bcd(min_v);
   assign hour_b = rbde_pkg::to_bcd(hour_v);
   assign day_b  = rbde_pkg::to_bcd({2'd0, dval});
   assign mon_b  = rbde_pkg::to_bcd({3'd0, dt_in.month_number});
   assign year_b = rbde_pkg::to_bcd(yval);

   rbde_weekday u_weekday (
      .day_of_month (dt_in.day_of_month),
      .month_number (dt_in.month_number),
      .year_full    (dt_in.year_full),
      .weekday_code (weekday)
   );

   always_comb begin
      dt_out.second_bcd        = sec_b[6:0];
      dt_out.minute_bcd        = min_b[6:0];
      dt_out.hour_bcd          = hour_b[5:0];
      dt_out.day_bcd           = day_b[5:0];
      dt_out.weekday_code      = weekday;
      dt_out.month_century_reg = {century, mon_b[6:0]};
      dt_out.year_bcd          = year_b;
      dt_out.month_invalid     = bad_month;
   end

endmodule

// ===== src/rtc_bcd_datetime_encode.sv =====
// RTC BCD date/time encoder, top level: input register, conversion logic, result register.
// Beats pass from the input register to the result register, which drives rsp_tvalid.
// Throughput: one beat per cycle while rsp_tready is high; with the result stalled the input
// register takes one more beat, then req_tready drops until the result register frees.
// Reset: synchronous, active high; clears both valid flags, payload is not reset.
// Depends on rbde_pkg and rbde_encode.
`timescale 1ns / 1ps

module rtc_bcd_datetime_encode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // second[6:0], minute[13:7], hour[20:14], day_of_month[26:21], month_number[30:27],
   // year_full[42:31], zero pad [47:43]
   input  logic [rbde_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // second_bcd[6:0], minute_bcd[13:7], hour_bcd[19:14], day_bcd[25:20],
   // weekday_code[28:26], month_century_reg[36:29], year_bcd[44:37], zero pad [47:45]
   output logic [rbde_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // month_invalid[0]
   output logic                            rsp_tuser
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   rbde_pkg::dt_in_type  in_data_ff;
   rbde_pkg::dt_in_type  in_data_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rbde_pkg::dt_out_type out_data_ff;
   rbde_pkg::dt_out_type out_data_in;
   rbde_pkg::dt_out_type conv;
   logic                 out_free;
   logic                 advance;
   logic                 req_beat;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_data_in.second       = req_tdata[6:0];
      in_data_in.minute       = req_tdata[13:7];
      in_data_in.hour         = req_tdata[20:14];
      in_data_in.day_of_month = req_tdata[26:21];
      in_data_in.month_number = req_tdata[30:27];
      in_data_in.year_full    = req_tdata[42:31];
   end

   assign in_valid_in  = req_beat || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign out_data_in  = conv;

   rbde_encode u_encode (
      .dt_in  (in_data_ff),
      .dt_out (conv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_data_ff <= in_data_in;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0,
                        out_data_ff.year_bcd,
                        out_data_ff.month_century_reg,
                        out_data_ff.weekday_code,
                        out_data_ff.day_bcd,
                        out_data_ff.hour_bcd,
                        out_data_ff.minute_bcd,
                        out_data_ff.second_bcd};
   assign rsp_tuser  = out_data_ff.month_invalid;

endmodule

// ===== dv/tb_rtc_bcd_datetime_encode.sv =====
// Self-checking testbench for rtc_bcd_datetime_encode: drives binary dates on the req stream
// and checks each rsp beat against an in-bench BCD register encoder. Depends on rbde_pkg.
`timescale 1ns / 1ps

module tb_rtc_bcd_datetime_encode;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 450;
   localparam int MAX_GAP     = 200;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // second[6:0], minute[13:7], hour[20:14], day_of_month[26:21], month_number[30:27],
   // year_full[42:31], zero pad [47:43]
   logic [rbde_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // second_bcd[6:0], minute_bcd[13:7], hour_bcd[19:14], day_bcd[25:20],
   // weekday_code[28:26], month_century_reg[36:29], year_bcd[44:37], zero pad [47:45]
   logic [rbde_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // month_invalid[0]
   logic                            rsp_tuser;

   rbde_pkg::dt_out_type pending_regs[$];
   int         tx_idle_pct  = 0;
   int         rx_stall_pct = 0;
   int         cycle_count  = 0;
   int         mismatches   = 0;
   int         dates_sent   = 0;
   int         regs_checked = 0;
   int         bad_months   = 0;
   int         directed_cnt = 0;

   rtc_bcd_datetime_encode DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- encoder model ----------------
   function automatic logic [7:0] bin_to_bcd(input int unsigned v);
      return 8'(((v / 10) << 4) + (v % 10));
   endfunction

   function automatic bit is_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // month 1..12; anything else counts as a 31-day month
   function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
      int unsigned len;
      case (m)
         4, 6, 9, 11: len = 30;
         2:           len = is_leap(y) ? 29 : 28;
         default:     len = 31;
      endcase
      return len;
   endfunction

   function automatic rbde_pkg::dt_out_type encode_date(input rbde_pkg::dt_in_type d);
      rbde_pkg::dt_out_type r;
      int unsigned mlen, dval, yval, cen, m, y, wd;
      bit          bad;
      bad  = (d.month_number < 1) || (d.month_number > 12);
      mlen = month_length(d.month_number, d.year_full);
      if (d.day_of_month > mlen) dval = mlen;
      else if (d.day_of_month > 0) dval = d.day_of_month;
      else dval = 1;
      cen = 0;
      if (d.year_full >= 2100) begin
         yval = 99;
      end else if (d.year_full >= 2000) begin
         yval = d.year_full - 2000;
      end else if (d.year_full >= 1900) begin
         yval = d.year_full - 1900;
         cen  = 'h80;
      end else begin
         yval = 0;
         cen  = 'h80;
      end
      // weekday uses the raw day, month and year; Jan/Feb belong to the previous year
      m = d.month_number;
      y = d.year_full;
      if (m == 1 || m == 2) begin
         m = m + 12;
         y = (y > 0) ? y - 1 : 0;
      end
      wd = (d.day_of_month + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400 + 1)
           % 7;
      r.second_bcd        = 7'(bin_to_bcd(d.second < 60 ? d.second : 0));
      r.minute_bcd        = 7'(bin_to_bcd(d.minute < 60 ? d.minute : 0));
      r.hour_bcd          = 6'(bin_to_bcd(d.hour < 24 ? d.hour : 0));
      r.day_bcd           = 6'(bin_to_bcd(dval));
      r.weekday_code      = 3'(wd);
      r.month_century_reg = 8'(cen) | (bin_to_bcd(d.month_number) & 8'h7F);
      r.year_bcd          = bin_to_bcd(yval);
      r.month_invalid     = bad;
      return r;
   endfunction

   function automatic rbde_pkg::dt_in_type make_date(input int s, input int mi, input int h,
                                                     input int d, input int mo, input int y);
      rbde_pkg::dt_in_type t;
      t.second       = 7'(s);
      t.minute       = 7'(mi);
      t.hour         = 7'(h);
      t.day_of_month = 6'(d);
      t.month_number = 4'(mo);
      t.year_full    = 12'(y);
      return t;
   endfunction

   // ---------------- req side ----------------
   // Entered and left at a falling edge.
   task automatic send_date(input rbde_pkg::dt_in_type d);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, d.year_full, d.month_number, d.day_of_month,
                     d.hour, d.minute, d.second};
      do @(posedge clock); while (!req_tready);
      pending_regs.push_back(encode_date(d));
      dates_sent++;
      if (d.month_number < 1 || d.month_number > 12) bad_months++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_regs.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------- rsp side ----------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      rbde_pkg::dt_out_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.second_bcd        = rsp_tdata[6:0];
         got.minute_bcd        = rsp_tdata[13:7];
         got.hour_bcd          = rsp_tdata[19:14];
         got.day_bcd           = rsp_tdata[25:20];
         got.weekday_code      = rsp_tdata[28:26];
         got.month_century_reg = rsp_tdata[36:29];
         got.year_bcd          = rsp_tdata[44:37];
         got.month_invalid     = rsp_tuser;
         if (pending_regs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: rsp beat with no date outstanding, tdata=%h", $realtime,
                        rsp_tdata);
         end else begin
            want = pending_regs.pop_front();
            regs_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch sec/min/hr/day/wd/mc/yr/inv exp ",
                            "%h %h %h %h %0d %h %h %b got %h %h %h %h %0d %h %h %b"},
                           $realtime,
                           want.second_bcd, want.minute_bcd, want.hour_bcd, want.day_bcd,
                           want.weekday_code, want.month_century_reg, want.year_bcd,
                           want.month_invalid,
                           got.second_bcd, got.minute_bcd, got.hour_bcd, got.day_bcd,
                           got.weekday_code, got.month_century_reg, got.year_bcd,
                           got.month_invalid);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0d dates sent, %0d results checked at timeout", dates_sent,
                  regs_checked);
         $display("rtc_bcd_datetime_encode regression: fail");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_field_extremes();
      send_date(make_date(0, 0, 0, 0, 0, 0));            // day zero, bad month, year zero
      send_date(make_date(127, 127, 127, 63, 15, 4095)); // all ones
      send_date(make_date(59, 59, 23, 31, 12, 1999));
      send_date(make_date(60, 60, 24, 1, 1, 2000));      // time fields just past range
      send_date(make_date(85, 42, 99, 40, 13, 2050));    // bad month clamps day to 31
      send_date(make_date(1, 2, 3, 0, 6, 1850));         // day zero, pre-1900
      send_date(make_date(7, 8, 9, 5, 1, 1));            // January of year 1 -> year 0
      send_date(make_date(10, 20, 12, 15, 2, 0));
      directed_cnt += 8;
   endtask

   task automatic test_calendar_edges();
      send_date(make_date(0, 0, 0, 29, 2, 2000));   // leap by 400 rule
      send_date(make_date(0, 0, 0, 29, 2, 1900));   // not leap by 100 rule
      send_date(make_date(0, 0, 0, 30, 2, 2024));
      send_date(make_date(0, 0, 0, 29, 2, 2023));
      send_date(make_date(0, 0, 0, 29, 2, 2100));
      send_date(make_date(0, 0, 0, 31, 4, 2010));   // 30-day month overflow
      send_date(make_date(30, 30, 12, 31, 12, 2099));
      send_date(make_date(30, 30, 12, 1, 1, 2100)); // saturation starts
      send_date(make_date(30, 30, 12, 1, 1, 1900));
      send_date(make_date(30, 30, 12, 31, 12, 1899));
      send_date(make_date(45, 15, 20, 14, 7, 2025));
      send_date(make_date(0, 0, 0, 1, 11, 2000));
      directed_cnt += 12;
   endtask

   function automatic rbde_pkg::dt_in_type random_date();
      rbde_pkg::dt_in_type t;
      int unsigned y, m;
      if ($urandom_range(99) < 75) begin
         case ($urandom_range(9))
            0:       y = $urandom_range(4095);
            1:       y = $urandom_range(1899, 1);
            2, 3:    y = $urandom_range(1999, 1900);
            4, 5, 6: y = $urandom_range(2099, 2000);
            default: y = $urandom_range(2150, 2095);
         endcase
         m = $urandom_range(12, 1);
         // most days legal, some past the month end to exercise clamping
         t = make_date($urandom_range(59), $urandom_range(59), $urandom_range(23),
                       ($urandom_range(9) == 0) ? $urandom_range(31, 28)
                                                 : $urandom_range(month_length(m, y), 1),
                       m, y);
      end else begin
         t = make_date($urandom_range(127), $urandom_range(127), $urandom_range(127),
                       $urandom_range(63), $urandom_range(15), $urandom_range(4095));
      end
      return t;
   endfunction

   task automatic test_random_dates(input int count, input int tx_idle, input int rx_stall);
      tx_idle_pct  = tx_idle;
      rx_stall_pct = rx_stall;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_for_drain();
         send_date(random_date());
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_field_extremes();
      test_calendar_edges();
      test_random_dates(PHASE_ITEMS, 0, 0);
      test_random_dates(PHASE_ITEMS, 88, 0);
      test_random_dates(PHASE_ITEMS, 0, 88);
      test_random_dates(PHASE_ITEMS, 16, 16);
      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("covered %0d dates (%0d directed, %0d with a bad month), %0d results checked",
               dates_sent, directed_cnt, bad_months, regs_checked);
      $display("phases: free flow, sender idle, receiver stall, both; %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_regs.size() == 0) begin
         $display("rtc_bcd_datetime_encode regression: pass");
      end else begin
         $display("rtc_bcd_datetime_encode regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rbde_pkg.sv
src/rbde_weekday.sv
src/rbde_encode.sv
src/rtc_bcd_datetime_encode.sv
dv/tb_rtc_bcd_datetime_encode.sv
